/* hw/rtl/hss_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hss_pkg: shared types and constants of the hermite segment sampler
// knot command and result item layouts, back-end states, arithmetic widths
// ----------------------------------------------------------------------------
package hss_pkg;

   localparam int CoordW = 32;   // Q16.16 coordinate
   localparam int ArcW   = 40;   // Q24.16 arc length
   localparam int QW     = 48;   // signed quotient of a scaled polynomial term
   localparam int RW     = 18;   // remainder, holds any divisor up to 63^3
   localparam int RadW   = 66;   // sum of three squared chord components
   localparam int RootW  = 33;   // chord length

   typedef enum logic [0:0] {
      KIND_START,
      KIND_SEGMENT
   } knot_kind_type;

   typedef struct packed {
      logic [2:0][CoordW-1:0] point;
      logic [2:0][CoordW-1:0] tangent;
      knot_kind_type          kind;
   } knot_cmd_type;

   typedef struct packed {
      logic [2:0][CoordW-1:0] sample;
      logic [ArcW-1:0]        arc;
      logic                   last;
   } result_type;

   // value held as floor quotient and remainder against the fixed divisor
   typedef struct packed {
      logic [QW-1:0] q;
      logic [RW-1:0] r;
   } qr_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_COEF1,
      B_COEF2,
      B_DIVIDE,
      B_DIV_WAIT,
      B_SAMPLE,
      B_SQUARE,
      B_ROOT,
      B_ROOT_WAIT,
      B_EMIT
   } back_state_type;

   function automatic logic signed [QW-1:0] sx48(logic [CoordW-1:0] v);
      return {{(QW-CoordW){v[CoordW-1]}}, v};
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/hss_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hss_fifo: small first-in first-out queue
// flop-based entries, push/pop with full and empty flags
// ----------------------------------------------------------------------------
module hss_fifo #(
   parameter int Width = 8,
   parameter int Depth = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [Width-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [Width-1:0] rd_data,
   output logic             empty
);
   localparam int PW = $clog2(Depth);
   localparam int CW = $clog2(Depth + 1);
   localparam logic [PW-1:0] LastPtr = PW'(Depth - 1);
   localparam logic [CW-1:0] FullCnt = CW'(Depth);

   logic [Width-1:0] mem_ff [Depth];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == FullCnt);
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CW'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/hss_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hss_div: constant-divisor floor divider
// signed dividend over a fixed positive divisor, one 12-bit quotient digit at
// a time, each from a reciprocal estimate and one correction step
// ----------------------------------------------------------------------------
module hss_div #(
   parameter int Divisor = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [hss_pkg::QW-1:0]    dividend,
   output logic                      busy,
   output hss_pkg::qr_type           result
);
   import hss_pkg::*;

   localparam int DigW   = 12;             // quotient bits per digit
   localparam int Digits = QW / DigW;
   localparam int XW     = RW + DigW;       // partial dividend
   localparam int MW     = XW + 1;          // reciprocal
   localparam int PW     = XW + MW;
   localparam int CntW   = $clog2(Digits + 1);
   localparam logic [RW-1:0] Dv    = RW'(Divisor);
   localparam logic [MW-1:0] Recip = MW'((64'd1 << XW) / 64'(Divisor));

   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            fix_ff, fix_in;
   logic            neg_ff, neg_in;
   logic [QW-1:0]   quo_ff, quo_in;
   logic [RW-1:0]   rem_ff, rem_in;
   logic [DigW-1:0] qe_ff, qe_in;
   logic [XW-1:0]   x_cur, r_est;
   logic [PW-1:0]   prod;

   assign busy  = (cnt_ff != '0);
   // remainder so far with the next dividend digit appended
   assign x_cur = {rem_ff, quo_ff[QW-1 -: DigW]};
   // estimate is the true digit or one below it
   assign prod  = PW'(x_cur) * PW'(Recip);
   assign r_est = x_cur - XW'(qe_ff) * XW'(Dv);

   always_comb begin
      neg_in = neg_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      qe_in  = qe_ff;
      fix_in = fix_ff;
      cnt_in = cnt_ff;
      if (start) begin
         neg_in = dividend[QW-1];
         quo_in = dividend[QW-1] ? QW'(-dividend) : dividend;
         rem_in = '0;
         fix_in = 1'b0;
         cnt_in = CntW'(Digits);
      end else if (busy && !fix_ff) begin
         qe_in  = prod[XW +: DigW];
         fix_in = 1'b1;
      end else if (busy) begin
         if (r_est >= XW'(Dv)) begin
            rem_in = RW'(r_est - XW'(Dv));
            quo_in = {quo_ff[QW-DigW-1:0], qe_ff + DigW'(1)};
         end else begin
            rem_in = RW'(r_est);
            quo_in = {quo_ff[QW-DigW-1:0], qe_ff};
         end
         fix_in = 1'b0;
         cnt_in = cnt_ff - CntW'(1);
      end
   end

   // turn the magnitude result into floor quotient and nonnegative remainder
   always_comb begin
      if (neg_ff && rem_ff != '0) begin
         result.q = ~quo_ff;
         result.r = Dv - rem_ff;
      end else if (neg_ff) begin
         result.q = QW'(-quo_ff);
         result.r = '0;
      end else begin
         result.q = quo_ff;
         result.r = rem_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         fix_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         fix_ff <= fix_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      qe_ff  <= qe_in;
   end

endmodule

`default_nettype wire

/* hw/rtl/hss_isqrt.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hss_isqrt: iterative integer square root
// floor root of a 66-bit radicand, two radicand bits per cycle
// ----------------------------------------------------------------------------
module hss_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [hss_pkg::RadW-1:0]    radicand,
   output logic                        busy,
   output logic [hss_pkg::RootW-1:0]   root
);
   import hss_pkg::*;

   localparam int Steps = RadW / 2;
   localparam int CntW  = $clog2(Steps + 1);
   localparam int RemW  = RootW + 3;

   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic [RadW-1:0]  rad_ff, rad_in;
   logic [RemW-1:0]  rem_ff, rem_in;
   logic [RootW-1:0] root_ff, root_in;
   logic [RemW-1:0]  rem_sh, trial;

   assign busy = (cnt_ff != '0);
   assign root = root_ff;

   always_comb begin
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      rem_sh  = {rem_ff[RemW-3:0], rad_ff[RadW-1:RadW-2]};
      trial   = RemW'({root_ff, 2'b01});
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CntW'(Steps);
      end else if (busy) begin
         rad_in = {rad_ff[RadW-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[RootW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[RootW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

endmodule

`default_nettype wire

/* hw/rtl/hss_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hss_front: knot intake
// accepts knots, marks each as curve start or segment end, queues them
// ----------------------------------------------------------------------------
module hss_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic [2:0][hss_pkg::CoordW-1:0]    point,
   input  logic [2:0][hss_pkg::CoordW-1:0]    tangent,
   input  logic                               starts_curve,
   output hss_pkg::knot_cmd_type              cmd,
   output logic                               cmd_empty,
   input  logic                               cmd_pop
);
   import hss_pkg::*;

   logic         have_knot_ff, have_knot_in;
   logic         accept;
   knot_cmd_type cmd_in;
   logic [$bits(knot_cmd_type)-1:0] cmd_bits;

   assign accept       = push && !full;
   assign have_knot_in = have_knot_ff || accept;

   // a continuing knot with nothing stored behaves as a curve start
   always_comb begin
      cmd_in.point   = point;
      cmd_in.tangent = tangent;
      cmd_in.kind    = (starts_curve || !have_knot_ff) ? KIND_START : KIND_SEGMENT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_knot_ff <= 1'b0;
      end else begin
         have_knot_ff <= have_knot_in;
      end
   end

   hss_fifo #(
      .Width ($bits(knot_cmd_type)),
      .Depth (2)
   ) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (cmd_in),
      .full    (full),
      .rd_en   (cmd_pop),
      .rd_data (cmd_bits),
      .empty   (cmd_empty)
   );

   assign cmd = knot_cmd_type'(cmd_bits);

endmodule

`default_nettype wire

/* hw/rtl/hss_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hss_back: segment engine
// forward-difference hermite evaluation, chord length and item emission
// ----------------------------------------------------------------------------
module hss_back #(
   parameter int Samples = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  hss_pkg::knot_cmd_type cmd,
   input  logic                  cmd_empty,
   output logic                  cmd_pop,
   output hss_pkg::result_type   res_data,
   output logic                  res_push,
   input  logic                  res_full
);
   import hss_pkg::*;

   localparam int IW = $clog2(Samples);
   localparam logic [IW-1:0]        LastIdx = IW'(Samples - 1);
   localparam logic [RW-1:0]        Divisor = RW'((Samples - 1) * (Samples - 1) * (Samples - 1));
   localparam logic signed [7:0]    NStep   = 8'(Samples - 1);
   localparam logic signed [12:0]   NSq     = 13'((Samples - 1) * (Samples - 1));

   back_state_type state_ff, state_in;

   logic [CoordW-1:0]     pt_ff [3];
   logic [CoordW-1:0]     tg_ff [3];
   logic [CoordW-1:0]     prev_samp_ff [3];
   logic [CoordW-1:0]     cur_ff [3];
   logic signed [34:0]    a_ff [3];
   logic signed [35:0]    e_ff [3];
   logic signed [41:0]    b_ff [3];
   logic signed [43:0]    c_ff [3];
   qr_type                n_ff [3];
   qr_type                d1_ff [3];
   qr_type                d2_ff [3];
   qr_type                d3_ff [3];
   logic [2*RootW-2:0]    sq_ff [3];
   logic [IW-1:0]         i_ff;
   logic [ArcW-1:0]       len_ff;

   logic signed [QW-1:0]  a_wide [3];
   logic signed [QW-1:0]  e_wide [3];
   logic signed [QW-1:0]  dvd [3][3];
   qr_type                div_res [3][3];
   logic                  div_busy [3][3];
   logic                  div_start, div_done;
   logic [CoordW-1:0]     round_val [3];
   logic [2*RootW-2:0]    sq_in [3];
   logic [RadW-1:0]       radicand;
   logic                  sqrt_start, sqrt_busy;
   logic [RootW-1:0]      root;
   logic [ArcW:0]         len_sum;
   logic                  is_last;

   function automatic logic [CoordW-1:0] round_qr(qr_type v, logic [RW-1:0] dv);
      logic [RW:0] twice;
      logic        up;
      twice = {v.r, 1'b0};
      up    = v.q[QW-1] ? (twice > {1'b0, dv}) : (twice >= {1'b0, dv});
      return CoordW'(v.q + QW'(up));
   endfunction

   function automatic qr_type qr_add(qr_type x, qr_type y, logic [RW-1:0] dv);
      logic [RW:0] rs;
      qr_type      o;
      rs = {1'b0, x.r} + {1'b0, y.r};
      if (rs >= {1'b0, dv}) begin
         o.r = RW'(rs - {1'b0, dv});
         o.q = x.q + y.q + QW'(1);
      end else begin
         o.r = rs[RW-1:0];
         o.q = x.q + y.q;
      end
      return o;
   endfunction

   assign is_last = (i_ff == LastIdx);

   // cubic coefficients in i, scaled by n^3:
   //   A = 2p0-2p1+d0+d1, B = n(3(p1-p0)-2d0-d1), C = n^2 d0, D = n^3 p0
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         a_wide[k] = (sx48(pt_ff[k]) <<< 1) - (sx48(cmd.point[k]) <<< 1)
                   + sx48(tg_ff[k]) + sx48(cmd.tangent[k]);
         e_wide[k] = ((sx48(cmd.point[k]) - sx48(pt_ff[k])) <<< 1)
                   + (sx48(cmd.point[k]) - sx48(pt_ff[k]))
                   - (sx48(tg_ff[k]) <<< 1) - sx48(cmd.tangent[k]);
         // forward differences at i = 0: A+B+C, 6A+2B, 6A
         dvd[k][0] = QW'(a_ff[k]) + QW'(b_ff[k]) + QW'(c_ff[k]);
         dvd[k][1] = (QW'(a_ff[k]) <<< 2) + (QW'(a_ff[k]) <<< 1) + (QW'(b_ff[k]) <<< 1);
         dvd[k][2] = (QW'(a_ff[k]) <<< 2) + (QW'(a_ff[k]) <<< 1);
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_axis
      for (genvar j = 0; j < 3; j++) begin : g_term
         hss_div #(
            .Divisor (Divisor)
         ) u_div (
            .clock    (clock),
            .reset    (reset),
            .start    (div_start),
            .dividend (dvd[k][j]),
            .busy     (div_busy[k][j]),
            .result   (div_res[k][j])
         );
      end
   end

   always_comb begin
      div_done = 1'b1;
      for (int k = 0; k < 3; k++) begin
         for (int j = 0; j < 3; j++) begin
            div_done = div_done && !div_busy[k][j];
         end
      end
   end

   always_comb begin
      logic signed [CoordW:0] df;
      logic [CoordW:0]        mg;
      for (int k = 0; k < 3; k++) begin
         round_val[k] = round_qr(n_ff[k], Divisor);
         df           = {cur_ff[k][CoordW-1], cur_ff[k]}
                      - {prev_samp_ff[k][CoordW-1], prev_samp_ff[k]};
         mg           = df[CoordW] ? (CoordW+1)'(-df) : df;
         sq_in[k]     = (2*RootW-1)'(mg) * (2*RootW-1)'(mg);
      end
      radicand = RadW'(sq_ff[0]) + RadW'(sq_ff[1]) + RadW'(sq_ff[2]);
      len_sum  = {1'b0, len_ff} + (ArcW+1)'(root);
   end

   hss_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (radicand),
      .busy     (sqrt_busy),
      .root     (root)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (!cmd_empty && cmd.kind == KIND_SEGMENT) begin
               state_in = B_COEF1;
            end
         end
         B_COEF1:  state_in = B_COEF2;
         B_COEF2:  state_in = B_DIVIDE;
         B_DIVIDE: state_in = B_DIV_WAIT;
         B_DIV_WAIT: begin
            if (div_done) begin
               state_in = B_SAMPLE;
            end
         end
         B_SAMPLE: state_in = (i_ff == '0) ? B_EMIT : B_SQUARE;
         B_SQUARE: state_in = B_ROOT;
         B_ROOT:   state_in = B_ROOT_WAIT;
         B_ROOT_WAIT: begin
            if (!sqrt_busy) begin
               state_in = B_EMIT;
            end
         end
         B_EMIT: begin
            if (!res_full) begin
               state_in = is_last ? B_IDLE : B_SAMPLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd_pop    = 1'b0;
      div_start  = 1'b0;
      sqrt_start = 1'b0;
      res_push   = 1'b0;
      case (state_ff)
         B_IDLE:   cmd_pop = !cmd_empty && cmd.kind == KIND_START;
         B_DIVIDE: div_start = 1'b1;
         B_ROOT:   sqrt_start = 1'b1;
         B_EMIT: begin
            res_push = !res_full;
            cmd_pop  = !res_full && is_last;
         end
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         res_data.sample[k] = cur_ff[k];
      end
      res_data.arc  = len_ff;
      res_data.last = is_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         len_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_IDLE && cmd_pop) begin
            len_ff <= '0;
         end else if (state_ff == B_ROOT_WAIT && !sqrt_busy) begin
            len_ff <= len_sum[ArcW] ? '1 : len_sum[ArcW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            if (cmd_pop) begin
               for (int k = 0; k < 3; k++) begin
                  pt_ff[k]        <= cmd.point[k];
                  tg_ff[k]        <= cmd.tangent[k];
                  prev_samp_ff[k] <= cmd.point[k];
               end
            end
         end
         B_COEF1: begin
            for (int k = 0; k < 3; k++) begin
               a_ff[k] <= a_wide[k][34:0];
               e_ff[k] <= e_wide[k][35:0];
            end
         end
         B_COEF2: begin
            for (int k = 0; k < 3; k++) begin
               b_ff[k] <= 42'(e_ff[k] * NStep);
               c_ff[k] <= 44'($signed(sx48(tg_ff[k])) * NSq);
            end
         end
         B_DIV_WAIT: begin
            if (div_done) begin
               i_ff <= '0;
               for (int k = 0; k < 3; k++) begin
                  n_ff[k].q <= sx48(pt_ff[k]);
                  n_ff[k].r <= '0;
                  d1_ff[k]  <= div_res[k][0];
                  d2_ff[k]  <= div_res[k][1];
                  d3_ff[k]  <= div_res[k][2];
               end
            end
         end
         B_SAMPLE: begin
            for (int k = 0; k < 3; k++) begin
               cur_ff[k] <= round_val[k];
            end
         end
         B_SQUARE: begin
            for (int k = 0; k < 3; k++) begin
               sq_ff[k] <= sq_in[k];
            end
         end
         B_EMIT: begin
            if (res_push) begin
               i_ff <= i_ff + IW'(1);
               for (int k = 0; k < 3; k++) begin
                  prev_samp_ff[k] <= cur_ff[k];
                  n_ff[k]         <= qr_add(n_ff[k], d1_ff[k], Divisor);
                  d1_ff[k]        <= qr_add(d1_ff[k], d2_ff[k], Divisor);
                  d2_ff[k]        <= qr_add(d2_ff[k], d3_ff[k], Divisor);
                  if (is_last) begin
                     pt_ff[k] <= cmd.point[k];
                     tg_ff[k] <= cmd.tangent[k];
                  end
               end
            end
         end
         default: begin
            i_ff <= i_ff;
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (res_push && res_data.last) |=> (state_ff == B_IDLE))
      else $error("segment did not finish after its last item");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_SAMPLE) |-> (n_ff[0].r < Divisor && n_ff[1].r < Divisor
                                  && n_ff[2].r < Divisor))
      else $error("remainder out of range");

   a_first_is_knot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_SAMPLE && i_ff == '0) |=> (cur_ff[0] == pt_ff[0]
         && cur_ff[1] == pt_ff[1] && cur_ff[2] == pt_ff[2]))
      else $error("first sample differs from stored knot");

   a_cmd_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV_WAIT) |-> !cmd_empty)
      else $error("segment command left the queue early");
`endif

endmodule

`default_nettype wire

/* hw/rtl/hermite_segment_sampler.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hermite_segment_sampler: cubic hermite segment sampler
// samples the segment between consecutive knots with running arc length
// ----------------------------------------------------------------------------
// Each knot carries a Q16.16 point and tangent. A knot with starts_curve set
// (or the first knot after reset) is stored and clears the arc length; it
// makes no items. Any other knot closes the segment from the stored knot and
// makes SAMPLES items at t = i/(SAMPLES-1), each with the chord-sum arc
// length (saturating at 2^40-1); last_sample marks the final one. Knots are
// taken into a two-entry queue, so push sees full only when two knots wait.
// Steps: a curve start is handled entirely in the engine's idle state. A
// segment first forms its coefficients, then divides the forward-difference
// terms by (SAMPLES-1)^3 one 12-bit quotient digit at a time, then makes the
// first item directly and each further item after the 33-step square root of
// its chord. Emission is held while the result queue is full. Results leave
// through a two-entry queue.
// ----------------------------------------------------------------------------
module hermite_segment_sampler #(
   parameter int SAMPLES = 32
) (
   input  logic               clock,
   input  logic               reset,
   // knot input
   input  logic               req_push,
   output logic               req_full,
   input  logic signed [31:0] req_knot_x,
   input  logic signed [31:0] req_knot_y,
   input  logic signed [31:0] req_knot_z,
   input  logic signed [31:0] req_tangent_x,
   input  logic signed [31:0] req_tangent_y,
   input  logic signed [31:0] req_tangent_z,
   input  logic               req_starts_curve,
   // sample output
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [31:0] rsp_sample_x,
   output logic signed [31:0] rsp_sample_y,
   output logic signed [31:0] rsp_sample_z,
   output logic [39:0]        rsp_arc_length,
   output logic               rsp_last_sample
);
   import hss_pkg::*;

   logic [2:0][CoordW-1:0] point, tangent;
   knot_cmd_type           cmd;
   logic                   cmd_empty, cmd_pop;
   result_type             res_data, res_head;
   logic                   res_push, res_full;
   logic [$bits(result_type)-1:0] res_bits;

   // gather the per-axis ports into arrays
   assign point   = {req_knot_z, req_knot_y, req_knot_x};
   assign tangent = {req_tangent_z, req_tangent_y, req_tangent_x};

   // front: intake and classification
   hss_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (req_push),
      .full         (req_full),
      .point        (point),
      .tangent      (tangent),
      .starts_curve (req_starts_curve),
      .cmd          (cmd),
      .cmd_empty    (cmd_empty),
      .cmd_pop      (cmd_pop)
   );

   // back: segment evaluation
   hss_back #(
      .Samples (SAMPLES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .res_data  (res_data),
      .res_push  (res_push),
      .res_full  (res_full)
   );

   // result queue parts the engine from the consumer
   hss_fifo #(
      .Width ($bits(result_type)),
      .Depth (2)
   ) u_res_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (res_push),
      .wr_data (res_data),
      .full    (res_full),
      .rd_en   (rsp_pop),
      .rd_data (res_bits),
      .empty   (rsp_empty)
   );

   assign res_head        = result_type'(res_bits);
   assign rsp_sample_x    = res_head.sample[0];
   assign rsp_sample_y    = res_head.sample[1];
   assign rsp_sample_z    = res_head.sample[2];
   assign rsp_arc_length  = res_head.arc;
   assign rsp_last_sample = res_head.last;

endmodule

`default_nettype wire

/* sim/hermite_segment_sampler_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hermite_segment_sampler_test: self-checking bench for the segment sampler
// random knots with idle bursts on both sides, samples checked in order
// ----------------------------------------------------------------------------
// Each accepted knot goes through an in-bench model of the sampler. The model
// keeps its own copy of the stored knot, the last sample and the running
// length. A continuing knot yields the expected samples; every popped item is
// compared field by field with the oldest expected sample.
// ----------------------------------------------------------------------------
module hermite_segment_sampler_test;
   import hss_pkg::*;

   localparam int NumSamples = 32;
   localparam int Span       = NumSamples - 1;
   localparam int StallLimit = 5000;   // cycles with no handshake on either side
   localparam int TailCycles = 200;

   typedef struct {
      logic [2:0][31:0] point;
      logic [2:0][31:0] tangent;
      knot_kind_type    kind;
   } knot_type;

   typedef struct {
      logic [2:0][31:0] sample;
      logic [39:0]      arc;
      logic             last;
   } sample_type;

   logic clock;
   logic reset;

   logic               req_push;
   logic               req_full;
   logic signed [31:0] req_knot_x, req_knot_y, req_knot_z;
   logic signed [31:0] req_tangent_x, req_tangent_y, req_tangent_z;
   logic               req_starts_curve;
   logic               rsp_empty;
   logic               rsp_pop;
   logic signed [31:0] rsp_sample_x, rsp_sample_y, rsp_sample_z;
   logic [39:0]        rsp_arc_length;
   logic               rsp_last_sample;

   hermite_segment_sampler #(.SAMPLES(NumSamples)) dut (.*);

   // knots waiting for the driver, samples waiting for the sampler
   knot_type   pending_knots[$];
   sample_type expected_samples[$];
   int         errors = 0;
   bit         quiet;   // no idling in the last part of the run

   // model state
   logic [2:0][31:0] stored_point = '0, stored_tangent = '0, last_point = '0;
   logic             knot_held = 1'b0;
   logic [39:0]      path_length = '0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // one coordinate of the hermite blend at parameter i/Span, rounded
   function automatic logic [31:0] blend(longint p0, longint p1, longint d0,
                                         longint d1, longint i);
      longint n3, w00, w01, w10, w11, s, mag, q;
      n3  = longint'(Span) * Span * Span;
      w00 = 2 * i * i * i - 3 * i * i * Span + n3;
      w01 = 3 * i * i * Span - 2 * i * i * i;
      w10 = i * (Span - i) * (Span - i);
      w11 = i * i * (i - Span);
      s   = w00 * p0 + w01 * p1 + w10 * d0 + w11 * d1;
      mag = (s < 0) ? -s : s;
      q   = (2 * mag + n3) / (2 * n3);
      if (s < 0) q = -q;
      return q[31:0];
   endfunction

   // floor of the euclidean distance between two wrapped points
   function automatic logic [33:0] chord(logic [2:0][31:0] a, logic [2:0][31:0] b);
      logic [65:0] sum;
      logic [65:0] m;
      logic [67:0] c2;
      logic [33:0] r, c;
      longint      d;
      sum = '0;
      for (int k = 0; k < 3; k++) begin
         d   = longint'(signed'(a[k])) - longint'(signed'(b[k]));
         m   = (d < 0) ? 66'(-d) : 66'(d);
         sum = sum + m * m;
      end
      r = '0;
      for (int bitpos = 33; bitpos >= 0; bitpos--) begin
         c  = r | (34'd1 << bitpos);
         c2 = 68'(c) * 68'(c);
         if (c2 <= 68'(sum)) r = c;
      end
      return r;
   endfunction

   // advance the model by one knot and queue the samples it yields
   task automatic sample_segment(knot_type kn);
      logic [2:0][31:0] cur;
      logic [40:0]      acc;
      sample_type       s;
      if (kn.kind == KIND_START || !knot_held) begin
         stored_point   = kn.point;
         stored_tangent = kn.tangent;
         knot_held      = 1'b1;
         path_length    = '0;
         last_point     = kn.point;
         return;
      end
      for (int i = 0; i < NumSamples; i++) begin
         for (int k = 0; k < 3; k++)
            cur[k] = blend(longint'(signed'(stored_point[k])),
                           longint'(signed'(kn.point[k])),
                           longint'(signed'(stored_tangent[k])),
                           longint'(signed'(kn.tangent[k])), i);
         if (i > 0) begin
            // running length saturates at its top value
            acc = 41'(path_length) + 41'(chord(cur, last_point));
            path_length = acc[40] ? '1 : acc[39:0];
         end
         last_point = cur;
         s.sample   = cur;
         s.arc      = path_length;
         s.last     = (i == NumSamples - 1);
         expected_samples.push_back(s);
      end
      stored_point   = kn.point;
      stored_tangent = kn.tangent;
   endtask

   // driver: knots from the pending queue, idle bursts between them
   int send_gap;
   always @(posedge clock) begin
      knot_type nxt;
      bit       go;
      if (reset) begin
         req_push         <= 1'b0;
         send_gap         <= 0;
         req_knot_x       <= '0;
         req_knot_y       <= '0;
         req_knot_z       <= '0;
         req_tangent_x    <= '0;
         req_tangent_y    <= '0;
         req_tangent_z    <= '0;
         req_starts_curve <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            sample_segment(pending_knots.pop_front());
         end
         go = 1'b0;
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(1, 11) - 1;
         end else if (pending_knots.size() > 0) begin
            go = 1'b1;
         end
         // hold the current item while the queue is full
         if (req_push && req_full) go = 1'b1;
         req_push <= go;
         if (go && !(req_push && req_full)) begin
            nxt = pending_knots[0];
            req_knot_x       <= nxt.point[0];
            req_knot_y       <= nxt.point[1];
            req_knot_z       <= nxt.point[2];
            req_tangent_x    <= nxt.tangent[0];
            req_tangent_y    <= nxt.tangent[1];
            req_tangent_z    <= nxt.tangent[2];
            req_starts_curve <= (nxt.kind == KIND_START);
         end
      end
   end

   // monitor: pop with stall bursts, check against the oldest expectation
   int pop_gap;
   always @(posedge clock) begin
      sample_type e;
      if (reset) begin
         rsp_pop <= 1'b0;
         pop_gap <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_samples.size() == 0) begin
               $error("unexpected item: x %h y %h z %h", rsp_sample_x, rsp_sample_y,
                      rsp_sample_z);
               errors++;
            end else begin
               e = expected_samples.pop_front();
               if (rsp_sample_x !== e.sample[0]) begin
                  $error("sample_x expected %h actual %h", e.sample[0], rsp_sample_x);
                  errors++;
               end
               if (rsp_sample_y !== e.sample[1]) begin
                  $error("sample_y expected %h actual %h", e.sample[1], rsp_sample_y);
                  errors++;
               end
               if (rsp_sample_z !== e.sample[2]) begin
                  $error("sample_z expected %h actual %h", e.sample[2], rsp_sample_z);
                  errors++;
               end
               if (rsp_arc_length !== e.arc) begin
                  $error("arc_length expected %h actual %h", e.arc, rsp_arc_length);
                  errors++;
               end
               if (rsp_last_sample !== e.last) begin
                  $error("last_sample expected %b actual %b", e.last, rsp_last_sample);
                  errors++;
               end
            end
         end
         if (pop_gap > 0) begin
            pop_gap <= pop_gap - 1;
            rsp_pop <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            pop_gap <= $urandom_range(1, 11) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no handshake at all
   int idle_cycles;
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= StallLimit) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   function automatic knot_type make_knot(logic [31:0] px, logic [31:0] py,
                                          logic [31:0] pz, logic [31:0] tx,
                                          logic [31:0] ty, logic [31:0] tz,
                                          knot_kind_type kind);
      knot_type kn;
      kn.point   = {pz, py, px};
      kn.tangent = {tz, ty, tx};
      kn.kind    = kind;
      return kn;
   endfunction

   // random coordinate: mostly moderate, sometimes anywhere in range
   function automatic logic [31:0] coord();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return 32'($signed($urandom_range(0, 32'h3f_ffff)) - 32'sh20_0000);
   endfunction

   initial begin
      logic [31:0] hi, lo;
      quiet = 1'b0;
      reset = 1'b1;
      hi = 32'h7fff_ffff;
      lo = 32'h8000_0000;

      // continuing knot with nothing stored acts as a curve start
      pending_knots.push_back(make_knot(0, 0, 0, 0, 0, 0, KIND_SEGMENT));
      pending_knots.push_back(make_knot(0, 0, 0, 0, 0, 0, KIND_SEGMENT));
      pending_knots.push_back(make_knot(32'h1_0000, 32'hffff_0000, 32'h8000,
                                        32'h2_0000, 0, 32'hfffe_0000, KIND_SEGMENT));
      // opposite extremes of the point range
      pending_knots.push_back(make_knot(hi, hi, hi, 0, 0, 0, KIND_START));
      pending_knots.push_back(make_knot(lo, lo, lo, 0, 0, 0, KIND_SEGMENT));
      // huge tangents push the curve outside the range, samples wrap
      pending_knots.push_back(make_knot(hi, lo, 0, hi, lo, hi, KIND_SEGMENT));
      pending_knots.push_back(make_knot(lo, hi, 0, hi, hi, lo, KIND_SEGMENT));
      // long zigzag drives the running length into saturation
      pending_knots.push_back(make_knot(lo, lo, lo, lo, lo, lo, KIND_START));
      for (int j = 0; j < 8; j++)
         pending_knots.push_back(j % 2 ?
            make_knot(lo, lo, lo, hi, hi, hi, KIND_SEGMENT) :
            make_knot(hi, hi, hi, lo, lo, lo, KIND_SEGMENT));
      // a fresh start clears the length again
      pending_knots.push_back(make_knot(32'h10, 32'h20, 32'h30, 1, 1, 1, KIND_START));
      pending_knots.push_back(make_knot(32'h5_0000, 0, 32'hfffb_0000, 0, 32'h3_0000,
                                        0, KIND_SEGMENT));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // sender holds off until the directed part has fully drained
      while (pending_knots.size() > 0 || expected_samples.size() > 0)
         @(posedge clock);

      for (int j = 0; j < 390; j++) begin
         pending_knots.push_back(make_knot(coord(), coord(), coord(), coord(),
                                           coord(), coord(),
                                           ($urandom_range(0, 7) == 0) ? KIND_START :
                                                                         KIND_SEGMENT));
      end
      // last stretch of the run goes without idling
      while (pending_knots.size() > 30)
         @(posedge clock);
      quiet = 1'b1;

      while (pending_knots.size() > 0 || expected_samples.size() > 0)
         @(posedge clock);
      repeat (TailCycles) @(posedge clock);

      if (errors == 0 && expected_samples.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
